// ===== sv/lsd_pkg.sv =====
package lsd_pkg;

  // pipeline depths of the parts
  localparam int FRONT_LAT = 9;
  localparam int POW_LAT   = 3;
  localparam int GAIN_LAT  = 4;
  localparam int TDAM_Q_W  = 32;
  localparam int DISP_Q_W  = 40;
  localparam int PIPE_LAT  = FRONT_LAT + POW_LAT + GAIN_LAT + TDAM_Q_W + 1 + DISP_Q_W + 1;

  // datapath widths
  localparam int EPS_W = 56;   // Q24.32 reduced energy, below 2^56
  localparam int LOG_W = 40;   // signed Q.32 log2 domain
  localparam int DEN_W = 58;   // Q.32 denominator

  // register map (index = paddr[4:3])
  localparam logic [1:0] REG_ENERGY_FACTOR = 2'd0;
  localparam logic [1:0] REG_ELEC_LOSS     = 2'd1;
  localparam logic [1:0] REG_THRESHOLD     = 2'd2;
  localparam logic [1:0] REG_NRT_DIVISOR   = 2'd3;

  localparam logic [47:0] RST_ENERGY_FACTOR = 48'd6040000000;
  localparam logic [31:0] RST_ELEC_LOSS     = 32'd629000000;
  localparam logic [31:0] RST_THRESHOLD     = 32'd6400;
  localparam logic [31:0] RST_NRT_DIVISOR   = 32'd16000;

  // Q.16 coefficients of the power terms
  localparam logic [17:0] COEF_A = 18'd222877;
  localparam logic [14:0] COEF_B = 15'd26374;

  typedef struct packed {
    logic                    valid;
    logic                    eps_zero;
    logic [31:0]             energy;
    logic [EPS_W-1:0]        eps;
    logic signed [LOG_W-1:0] y6;
    logic signed [LOG_W-1:0] y34;
  } front_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2 mantissa table entry, Q.32, entry 2^tb is 1.0
  function automatic logic [32:0] log_entry(input int i, input int tb);
    logic [63:0] x;
    logic [32:0] f;
    if (i >= (1 << tb)) return 33'h1_0000_0000;
    x = 64'h8000_0000 + (64'(i) << (31 - tb));
    f = '0;
    for (int j = 0; j < 32; j++) begin
      x = (x * x) >> 31;
      f = f << 1;
      if (x >= 64'h1_0000_0000) begin
        f[0] = 1'b1;
        x = x >> 1;
      end
    end
    return f;
  endfunction

  // exp2 mantissa table entry, Q2.30, entry 2^tb is 2.0
  function automatic logic [31:0] exp_entry(input int i, input int tb);
    logic [63:0] roots [0:12];
    logic [63:0] m;
    if (i >= (1 << tb)) return 32'h8000_0000;
    roots[0] = 64'h8000_0000;
    for (int j = 1; j <= 12; j++) begin
      roots[j] = (j <= tb) ? isqrt64(roots[j-1] << 30) : 64'd0;
    end
    m = 64'h4000_0000;
    for (int j = 0; j < 12; j++) begin
      if (j < tb) begin
        if (((i >> (tb - 1 - j)) & 1) != 0) m = (m * roots[j+1]) >> 30;
      end
    end
    return m[31:0];
  endfunction

endpackage

// ===== sv/lsd_front.sv =====
module lsd_front #(
  parameter int TABLE_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         in_energy,
  input  logic [47:0]         energy_factor,
  output lsd_pkg::front_t     fout
);

  localparam int TSIZE = 1 << TABLE_BITS;
  localparam int RW    = 31 - TABLE_BITS;
  localparam int PW    = 33 + RW;
  localparam int EW    = lsd_pkg::EPS_W;
  localparam logic [39:0] U_OFF = 40'h30_0000_0000;  // 48.0, a multiple of 6
  localparam logic [39:0] Q_OFF = 40'h08_0000_0000;  // 48.0 / 6

  logic [32:0] log_rom [TSIZE+1];

  for (genvar i = 0; i <= TSIZE; i++) begin : g_log
    localparam logic [32:0] LV = lsd_pkg::log_entry(i, TABLE_BITS);
    assign log_rom[i] = LV;
  end

  // F1: partial products of E * energy_factor
  logic        v1;
  logic [31:0] e1;
  logic [55:0] pa1, pb1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    e1  <= in_energy;
    pa1 <= 56'(in_energy) * 56'(energy_factor[23:0]);
    pb1 <= 56'(in_energy) * 56'(energy_factor[47:24]);
  end

  // F2: eps = floor(E*ef / 2^24)
  logic          v2;
  logic [31:0]   e2;
  logic [EW-1:0] eps2;
  logic [79:0]   sum2;
  assign sum2 = {pb1, 24'b0} + {24'b0, pa1};
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    e2   <= e1;
    eps2 <= sum2[79:24];
  end

  // F3: leading one
  logic          v3, z3;
  logic [31:0]   e3;
  logic [EW-1:0] eps3;
  logic [5:0]    p3, lead;
  always_comb begin
    lead = '0;
    for (int k = 0; k < EW; k++) begin
      if (eps2[k]) lead = 6'(k);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    e3   <= e2;
    eps3 <= eps2;
    z3   <= (eps2 == '0);
    p3   <= lead;
  end

  // F4: normalize to 1.31
  logic                  v4, z4;
  logic [31:0]           e4;
  logic [EW-1:0]         eps4, norm;
  logic [TABLE_BITS-1:0] idx4;
  logic [RW-1:0]         rem4;
  logic signed [6:0]     int4;
  always_comb begin
    if (p3 > 6'd31) norm = eps3 >> (p3 - 6'd31);
    else            norm = eps3 << (6'd31 - p3);
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    e4   <= e3;
    eps4 <= eps3;
    z4   <= z3;
    idx4 <= norm[30 -: TABLE_BITS];
    rem4 <= norm[RW-1:0];
    int4 <= $signed(7'(p3) - 7'd32);
  end

  // F5: table lookup
  logic                v5, z5;
  logic [31:0]         e5;
  logic [EW-1:0]       eps5;
  logic [32:0]         t05, dif5;
  logic [RW-1:0]       rem5;
  logic signed [6:0]   int5;
  logic [TABLE_BITS:0] ia, ib;
  assign ia = {1'b0, idx4};
  assign ib = ia + 1'b1;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    e5   <= e4;
    eps5 <= eps4;
    z5   <= z4;
    t05  <= log_rom[ia];
    dif5 <= log_rom[ib] - log_rom[ia];
    rem5 <= rem4;
    int5 <= int4;
  end

  // F6: interpolation product
  logic              v6, z6;
  logic [31:0]       e6;
  logic [EW-1:0]     eps6;
  logic [32:0]       t06;
  logic [PW-1:0]     prod6;
  logic signed [6:0] int6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    e6    <= e5;
    eps6  <= eps5;
    z6    <= z5;
    t06   <= t05;
    prod6 <= PW'(dif5) * PW'(rem5);
    int6  <= int5;
  end

  // F7: log2 in signed Q.32
  logic          v7, z7;
  logic [31:0]   e7;
  logic [EW-1:0] eps7;
  logic [39:0]   l7;
  logic [32:0]   frac7;
  logic [32:0]   interp7;
  assign interp7 = prod6[PW-1:RW];
  assign frac7   = t06 + interp7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    e7   <= e6;
    eps7 <= eps6;
    z7   <= z6;
    l7   <= {int6[6], int6, 32'b0} + {7'b0, frac7};
  end

  // F8: l/6 by splitting (l+48)/2 over 2^19 and a reciprocal of 3; 3l/4 by shift
  logic          v8, z8;
  logic [31:0]   e8;
  logic [EW-1:0] eps8;
  logic [36:0]   m1_8;
  logic [40:0]   m2_8;
  logic [39:0]   y34_8;
  logic [39:0]   u8;
  logic [18:0]   vh, vl;
  logic [20:0]   w8;
  logic [41:0]   l3;
  assign u8  = l7 + U_OFF;
  assign vh  = u8[38:20];
  assign vl  = u8[19:1];
  assign w8  = 21'({vh, 1'b0}) + 21'(vl);
  assign l3  = {{2{l7[39]}}, l7} + {l7[39], l7, 1'b0};
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    e8    <= e7;
    eps8  <= eps7;
    z8    <= z7;
    m1_8  <= 37'(vh) * 37'(18'd174762);
    m2_8  <= 41'(w8) * 41'(20'd699051);
    y34_8 <= l3[41:2];
  end

  // F9: output register
  logic [39:0] q9;
  assign q9 = 40'(m1_8) + 40'(m2_8[40:21]);
  always_ff @(posedge clk) begin
    if (rst) fout.valid <= 1'b0;
    else     fout.valid <= v8;
    fout.eps_zero <= z8;
    fout.energy   <= e8;
    fout.eps      <= eps8;
    fout.y6       <= $signed(q9 - Q_OFF);
    fout.y34      <= $signed(y34_8);
  end

endmodule

// ===== sv/lsd_pow.sv =====
module lsd_pow #(
  parameter int TABLE_BITS = 8
) (
  input  logic                             clk,
  input  logic signed [lsd_pkg::LOG_W-1:0] y,
  output logic [63:0]                      p
);

  localparam int TSIZE = 1 << TABLE_BITS;
  localparam int ERW   = 32 - TABLE_BITS;
  localparam int PW    = 32 + ERW;

  logic [31:0] exp_rom [TSIZE+1];

  for (genvar i = 0; i <= TSIZE; i++) begin : g_exp
    localparam logic [31:0] EV = lsd_pkg::exp_entry(i, TABLE_BITS);
    assign exp_rom[i] = EV;
  end

  // P1: lookup
  logic [TABLE_BITS:0] ia, ib;
  logic signed [8:0]   s1;
  logic [31:0]         t01, dif1;
  logic [ERW-1:0]      rem1;
  assign ia = {1'b0, y[31 -: TABLE_BITS]};
  assign ib = ia + 1'b1;
  always_ff @(posedge clk) begin
    s1   <= $signed({y[39], y[39:32]}) + 9'sd2;
    t01  <= exp_rom[ia];
    dif1 <= exp_rom[ib] - exp_rom[ia];
    rem1 <= y[ERW-1:0];
  end

  // P2: interpolation product
  logic signed [8:0] s2;
  logic [31:0]       t02;
  logic [PW-1:0]     prod2;
  always_ff @(posedge clk) begin
    s2    <= s1;
    t02   <= t01;
    prod2 <= PW'(dif1) * PW'(rem1);
  end

  // P3: mantissa and scale into Q32.32
  logic [31:0] m3;
  logic [31:0] interp3;
  logic [8:0]  nsh;
  logic [63:0] pn;
  assign interp3 = prod2[PW-1:ERW];
  assign m3      = t02 + interp3;
  assign nsh     = 9'(-s2);
  always_comb begin
    if (s2 > 9'sd32)      pn = '1;
    else if (s2 >= 9'sd0) pn = {32'b0, m3} << s2[5:0];
    else if (nsh >= 9'd63) pn = '0;
    else                  pn = {32'b0, m3} >> nsh[5:0];
  end
  always_ff @(posedge clk) begin
    p <= pn;
  end

endmodule

// ===== sv/lsd_div.sv =====
module lsd_div #(
  parameter int Q_W    = 32,
  parameter int DEN_W  = 58,
  parameter int SIDE_W = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem_init,
  input  logic [Q_W-1:0]    num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] out_side
);

  // one quotient bit per stage, restoring
  logic              vv [Q_W];
  logic [DEN_W-1:0]  rr [Q_W];
  logic [Q_W-1:0]    nn [Q_W];
  logic [Q_W-1:0]    qq [Q_W];
  logic [DEN_W-1:0]  dd [Q_W];
  logic [SIDE_W-1:0] ss [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              pv;
    logic [DEN_W-1:0]  pr, pd;
    logic [Q_W-1:0]    pn, pq;
    logic [SIDE_W-1:0] ps;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pr = rem_init;
      assign pn = num;
      assign pq = '0;
      assign pd = den;
      assign ps = side;
    end else begin : g_next
      assign pv = vv[k-1];
      assign pr = rr[k-1];
      assign pn = nn[k-1];
      assign pq = qq[k-1];
      assign pd = dd[k-1];
      assign ps = ss[k-1];
    end

    assign trial = {pr, pn[Q_W-1]};
    assign ge    = (trial >= {1'b0, pd});

    always_ff @(posedge clk) begin
      if (rst) vv[k] <= 1'b0;
      else     vv[k] <= pv;
      rr[k] <= ge ? DEN_W'(trial - {1'b0, pd}) : trial[DEN_W-1:0];
      nn[k] <= pn << 1;
      qq[k] <= {pq[Q_W-2:0], ge};
      dd[k] <= pd;
      ss[k] <= ps;
    end
  end

  assign out_valid = vv[Q_W-1];
  assign quo       = qq[Q_W-1];
  assign out_side  = ss[Q_W-1];

endmodule

// ===== sv/lss_damage_energy_nrt_core.sv =====
// LSS damage energy and NRT displacement pipeline. Pulse start with a recoil
// energy (Q24.8 eV) and done later pulses for one cycle with the damage
// energy Tdam = E / (1 + kd*g(eps)) and the NRT count (0 below the threshold,
// else Tdam/divisor floored at 1.0, saturating). busy is always low: one item
// enters every cycle, and results come out in order. The pipeline runs
// through the log2/exp2 front end and the two long dividers (32 and 40
// stages, one quotient bit each). The receiver cannot hold results off, so
// done must be taken when shown. Material constants sit on the register port
// and must only change while no item is in flight.
module lss_damage_energy_nrt_core #(
  parameter int ENERGY_BITS    = 32,
  parameter int POW_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // item port
  input  logic        start,
  output logic        busy,
  input  logic [31:0] recoil_energy,
  output logic        done,
  output logic [31:0] damage_energy,
  output logic [31:0] displacements,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int EW = (ENERGY_BITS > 32) ? 32 : ENERGY_BITS;
  localparam logic [31:0] EMASK = 32'((64'd1 << EW) - 64'd1);
  localparam int PL = lsd_pkg::POW_LAT;
  localparam int DW = lsd_pkg::DEN_W;

  // ---------------- registers ----------------
  logic [47:0] energy_factor;
  logic [31:0] elec_loss;
  logic [31:0] threshold;
  logic [31:0] nrt_divisor;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_factor <= lsd_pkg::RST_ENERGY_FACTOR;
      elec_loss     <= lsd_pkg::RST_ELEC_LOSS;
      threshold     <= lsd_pkg::RST_THRESHOLD;
      nrt_divisor   <= lsd_pkg::RST_NRT_DIVISOR;
    end else if (wr_en) begin
      unique case (paddr[4:3])
        lsd_pkg::REG_ENERGY_FACTOR: energy_factor <= pwdata[47:0];
        lsd_pkg::REG_ELEC_LOSS:     elec_loss     <= pwdata[31:0];
        lsd_pkg::REG_THRESHOLD:     threshold     <= pwdata[31:0];
        lsd_pkg::REG_NRT_DIVISOR:   nrt_divisor   <= pwdata[31:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      lsd_pkg::REG_ENERGY_FACTOR: prdata = 64'(energy_factor);
      lsd_pkg::REG_ELEC_LOSS:     prdata = 64'(elec_loss);
      lsd_pkg::REG_THRESHOLD:     prdata = 64'(threshold);
      lsd_pkg::REG_NRT_DIVISOR:   prdata = 64'(nrt_divisor);
    endcase
  end

  // ---------------- front end: eps, log2, exponent scaling ----------------
  assign busy = 1'b0;

  lsd_pkg::front_t fo;

  lsd_front #(.TABLE_BITS(POW_TABLE_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .in_energy     (recoil_energy & EMASK),
    .energy_factor (energy_factor),
    .fout          (fo)
  );

  // eps^(1/6) and eps^(3/4)
  logic [63:0] p6, p34;

  lsd_pow #(.TABLE_BITS(POW_TABLE_BITS)) u_pow6 (
    .clk (clk),
    .y   (fo.y6),
    .p   (p6)
  );

  lsd_pow #(.TABLE_BITS(POW_TABLE_BITS)) u_pow34 (
    .clk (clk),
    .y   (fo.y34),
    .p   (p34)
  );

  // side data waits alongside the exp2 units
  logic        dv [PL];
  logic        dz [PL];
  logic [31:0] de [PL];
  logic [39:0] dh [PL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PL; k++) dv[k] <= 1'b0;
    end else begin
      dv[0] <= fo.valid;
      for (int k = 1; k < PL; k++) dv[k] <= dv[k-1];
    end
    dz[0] <= fo.eps_zero;
    de[0] <= fo.energy;
    dh[0] <= fo.eps[lsd_pkg::EPS_W-1:16];
    for (int k = 1; k < PL; k++) begin
      dz[k] <= dz[k-1];
      de[k] <= de[k-1];
      dh[k] <= dh[k-1];
    end
  end

  // ---------------- g and the denominator ----------------
  // G1: coefficient products (p34 split in halves)
  logic        g1_v, g1_z;
  logic [31:0] g1_e;
  logic [39:0] g1_h;
  logic [57:0] g1_a;
  logic [40:0] g1_bl, g1_bh;
  always_ff @(posedge clk) begin
    if (rst) g1_v <= 1'b0;
    else     g1_v <= dv[PL-1];
    g1_z  <= dz[PL-1];
    g1_e  <= de[PL-1];
    g1_h  <= dh[PL-1];
    g1_a  <= 58'(p6[39:0]) * 58'(lsd_pkg::COEF_A);
    g1_bl <= 41'(p34[25:0]) * 41'(lsd_pkg::COEF_B);
    g1_bh <= 41'(p34[51:26]) * 41'(lsd_pkg::COEF_B);
  end

  // G2: g in Q.16; both powers count as zero for zero eps
  logic        g2_v, g2_z;
  logic [31:0] g2_e;
  logic [41:0] g2_g;
  logic [66:0] b_full;
  logic [41:0] g_sum;
  assign b_full = {g1_bh, 26'b0} + 67'(g1_bl);
  assign g_sum  = 42'(g1_h) + 42'(g1_a[57:32]) + 42'(b_full[66:32]);
  always_ff @(posedge clk) begin
    if (rst) g2_v <= 1'b0;
    else     g2_v <= g1_v;
    g2_z <= g1_z;
    g2_e <= g1_e;
    g2_g <= g1_z ? '0 : g_sum;
  end

  // G3: kd * g, g split in halves
  logic        g3_v, g3_z;
  logic [31:0] g3_e;
  logic [52:0] kg_lo, kg_hi;
  always_ff @(posedge clk) begin
    if (rst) g3_v <= 1'b0;
    else     g3_v <= g2_v;
    g3_z  <= g2_z;
    g3_e  <= g2_e;
    kg_lo <= 53'(elec_loss) * 53'(g2_g[20:0]);
    kg_hi <= 53'(elec_loss) * 53'(g2_g[41:21]);
  end

  // G4: den = 1.0 + kd*g in Q.32
  logic          g4_v, g4_z;
  logic [31:0]   g4_e;
  logic [DW-1:0] g4_den;
  logic [73:0]   kg_full;
  assign kg_full = {kg_hi, 21'b0} + 74'(kg_lo);
  always_ff @(posedge clk) begin
    if (rst) g4_v <= 1'b0;
    else     g4_v <= g3_v;
    g4_z   <= g3_z;
    g4_e   <= g3_e;
    g4_den <= (DW'(1) << 32) + kg_full[73:16];
  end

  // ---------------- Tdam = E*2^32 / den ----------------
  logic        d1_v;
  logic [31:0] d1_q;
  logic [32:0] d1_side;

  lsd_div #(.Q_W(lsd_pkg::TDAM_Q_W), .DEN_W(DW), .SIDE_W(33)) u_div_tdam (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g4_v),
    .rem_init  (DW'(g4_e)),
    .num       ('0),
    .den       (g4_den),
    .side      ({g4_z, g4_e}),
    .out_valid (d1_v),
    .quo       (d1_q),
    .out_side  (d1_side)
  );

  // T: threshold test; zero eps gives Tdam = E directly
  logic        t_v, t_below;
  logic [31:0] t_tdam, tdam;
  assign tdam = d1_side[32] ? d1_side[31:0] : d1_q;
  always_ff @(posedge clk) begin
    if (rst) t_v <= 1'b0;
    else     t_v <= d1_v;
    t_tdam  <= tdam;
    t_below <= (tdam < threshold);
  end

  // ---------------- NRT count = Tdam*256 / divisor ----------------
  logic        d2_v;
  logic [39:0] d2_q;
  logic [32:0] d2_side;

  lsd_div #(.Q_W(lsd_pkg::DISP_Q_W), .DEN_W(32), .SIDE_W(33)) u_div_nrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_v),
    .rem_init  ('0),
    .num       ({t_tdam, 8'b0}),
    .den       (nrt_divisor),
    .side      ({t_below, t_tdam}),
    .out_valid (d2_v),
    .quo       (d2_q),
    .out_side  (d2_side)
  );

  // output: 0 below threshold, else floor at 1.0 and saturate; zero divisor gives all ones
  logic [31:0] disp;
  always_comb begin
    priority if (d2_side[32])              disp = '0;
    else if (d2_q < 40'd256)               disp = 32'd256;
    else if (d2_q > {8'b0, EMASK})         disp = EMASK;
    else                                   disp = d2_q[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= d2_v;
    damage_energy <= d2_side[31:0];
    displacements <= disp;
  end

endmodule

// ===== sv/lsd_checker.sv =====
module lsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] recoil_energy,
  input logic [31:0] damage_energy,
  input logic [31:0] displacements
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, lsd_pkg::PIPE_LAT))
    else $error("result without matching item");

  a_tdam_le_e: assert property (@(posedge clk) disable iff (rst)
    done |-> (damage_energy <= $past(recoil_energy, lsd_pkg::PIPE_LAT)))
    else $error("damage energy above recoil energy");

  a_disp_floor: assert property (@(posedge clk) disable iff (rst)
    done |-> (displacements == 32'd0 || displacements >= 32'd256))
    else $error("displacement count between zero and one");

endmodule

bind lss_damage_energy_nrt_core lsd_checker u_lsd_checker (.*);
